@@ rtl/core/chained_table_allocator_assert.svh @@
// Assertion macros for the chained table allocator
`ifndef CHAINED_TABLE_ALLOCATOR_ASSERT_SVH
`define CHAINED_TABLE_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define CTA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("chained table allocator: assertion failed");
// Next-cycle implication
`define CTA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("chained table allocator: assertion failed");
`else
`define CTA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CTA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/core/cta_pkg.sv @@
// Types and constants shared by the chained table allocator
`timescale 1ns / 1ps
`default_nettype none
package cta_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMPT,
    ST_CHECK,
    ST_SCAN1,
    ST_SCAN2,
    ST_SEAL,
    ST_MIRROR,
    ST_FMT,
    ST_WALK,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    OP_ALLOC          = 2'd0,
    OP_ALLOC_EMPTIEST = 2'd1,
    OP_FREE           = 2'd2,
    OP_FORMAT         = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_TOO_LONG = 2'd1,
    STAT_NO_SPACE = 2'd2,
    STAT_RAN_OUT  = 2'd3
  } status_e;

  localparam int unsigned EntriesPerTable = 256;
  localparam int unsigned MaxSectors      = 254;
  localparam logic [7:0]  FullFreeCount   = 8'd254;
  localparam logic [7:0]  RootFreeCount   = 8'd253;

endpackage
`default_nettype wire

@@ rtl/core/cta_ram.sv @@
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
`default_nettype none
module cta_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write, and read the old contents on a same-address collision
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

@@ rtl/core/chained_table_allocator.sv @@
// Chain table allocator: format, allocate and free over linked entry tables
// Allocate: the emptiest variant first visits each table's free count; up to two
//   ascending read passes over the entry memory (one entry a cycle) dominate.
// Free: walks the chain, freeing one link a cycle.
// Format: writes every entry of every table, one memory write a cycle.
// One transaction in flight; the result register frees the input side.
// Reset clears control only; table contents are undefined until a format.
`timescale 1ns / 1ps
`default_nettype none
`include "chained_table_allocator_assert.svh"
module chained_table_allocator #(
  parameter int unsigned TABLE_COUNT = 4,
  parameter int unsigned SECTOR_SIZE = 16,
  parameter int unsigned FREE_MARK   = 0,
  parameter int unsigned END_MARK    = 255,
  parameter int unsigned ROOT_TABLE  = 0,
  parameter int unsigned ROOT_ENTRY  = 1
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [1:0]  table_select_i,
  input  wire logic [15:0] byte_length_i,
  input  wire logic [7:0]  chain_head_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       status_o,
  output logic [1:0]       table_id_o,
  output logic [7:0]       head_entry_o,
  output logic [4:0]       tail_bytes_o,
  output logic [7:0]       free_left_o
);

  localparam int unsigned TW    = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;
  localparam int unsigned Depth = TABLE_COUNT * cta_pkg::EntriesPerTable;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned RW    = $clog2(SECTOR_SIZE) + 1;

  // Reciprocal of the sector size, exact for every 16-bit length
  localparam int unsigned DivShift = 16 + $clog2(SECTOR_SIZE);
  localparam logic [17:0] DivMul   =
    18'(((64'd1 << DivShift) + 64'(SECTOR_SIZE) - 64'd1) / 64'(SECTOR_SIZE));

  localparam logic [7:0]    FreeMark  = 8'(FREE_MARK);
  localparam logic [7:0]    EndMark   = 8'(END_MARK);
  localparam logic [7:0]    RootEntry = 8'(ROOT_ENTRY);
  localparam logic [RW-1:0] SecSize   = RW'(SECTOR_SIZE);
  localparam logic [TW-1:0] LastTable = TW'(TABLE_COUNT - 1);

  cta_pkg::state_e  state_q, state_d;
  cta_pkg::opcode_e op_q, op_d;
  cta_pkg::status_e stat_q, stat_d;

  logic [TW-1:0] t_q, t_d, emp_q, emp_d, best_q, best_d, ft_q, ft_d;
  logic [TW-1:0] sel_mod, fc_idx;
  logic [4:0]    sel_wide;
  logic [15:0]   q_q, q_d, len_q, len_d;
  logic [RW-1:0] rem_q, rem_d, tail_q, tail_d, tail_adj;
  logic [33:0]   div_prod;
  logic [15:0]   div_rem;
  logic          div_cnt_q, div_cnt_d;
  logic [7:0]    best_cnt_q, best_cnt_d, need_q, need_d, need_w;
  logic [7:0]    found_q, found_d, first_q, first_d, prev_q, prev_d;
  logic [7:0]    cnt_q, cnt_d, cur_q, cur_d, fe_q, fe_d, rd_e_q, rd_e_d;
  logic [8:0]    iss_q, iss_d;
  logic          rd_vld_q, rd_vld_d, walk_pend_q, walk_pend_d, fwd_q, fwd_d;
  logic          out_valid_q, out_valid_d;
  logic [1:0]    o_stat_q, o_stat_d, o_tid_q, o_tid_d;
  logic [7:0]    o_head_q, o_head_d, o_free_q, o_free_d;
  logic [4:0]    o_tail_q, o_tail_d;
  logic [7:0]    fc_q [TABLE_COUNT];
  logic [7:0]    fc_d [TABLE_COUNT];
  logic [7:0]    fc_rd;

  logic          in_acc, out_free, too_long, rd_hit, last_found, scan_end;
  logic          walk_stop, fmt_last, div_done, emp_done;
  logic [7:0]    walk_data, rd_entry, wr_entry, wr_data;
  logic [TW-1:0] wr_table;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_rdata;

  // Fold the table select into range
  always_comb begin
    sel_wide = 5'(table_select_i);
    for (int k = 0; k < 4; k++) begin
      if (sel_wide >= 5'(TABLE_COUNT)) begin
        sel_wide = sel_wide - 5'(TABLE_COUNT);
      end
    end
    sel_mod = TW'(sel_wide);
  end

  // Pick the free count read port address
  always_comb begin
    priority if (state_q == cta_pkg::ST_IDLE) begin
      fc_idx = sel_mod;
    end else if (state_q == cta_pkg::ST_EMPT) begin
      fc_idx = emp_q;
    end else begin
      fc_idx = t_q;
    end
  end
  assign fc_rd = fc_q[fc_idx];

  // Handshake flags
  assign in_ready_o = (state_q == cta_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // Sector count by reciprocal multiplication, remainder from the registered quotient
  assign div_prod = {18'd0, len_q} * {16'd0, DivMul};
  assign div_rem  = len_q - q_q * 16'(SECTOR_SIZE);
  assign div_done = div_cnt_q;
  assign emp_done = (emp_q == LastTable);
  assign tail_adj = (rem_q == '0 && q_q != 16'd0) ? SecSize : rem_q;
  assign too_long = (q_q > 16'(cta_pkg::MaxSectors));
  assign need_w   = q_q[7:0] + 8'd1 - {7'd0, (tail_adj == SecSize)};

  // Scan and walk flags
  assign rd_hit     = rd_vld_q && (rd_e_q != FreeMark) && (rd_e_q != EndMark)
                      && (ram_rdata == FreeMark);
  assign last_found = rd_hit && ((found_q + 8'd1) == need_q);
  assign scan_end   = rd_vld_q && (rd_e_q == 8'hFF);
  assign walk_data  = fwd_q ? FreeMark : ram_rdata;
  assign walk_stop  = (walk_data == EndMark) || (walk_data == FreeMark);
  assign fmt_last   = (ft_q == LastTable) && (fe_q == 8'hFF);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cta_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (cta_pkg::opcode_e'(opcode_i))
            cta_pkg::OP_FORMAT: state_d = cta_pkg::ST_FMT;
            cta_pkg::OP_FREE:   state_d = cta_pkg::ST_WALK;
            default:            state_d = cta_pkg::ST_DIV;
          endcase
        end
      end
      cta_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = (op_q == cta_pkg::OP_ALLOC_EMPTIEST) ? cta_pkg::ST_EMPT
                                                         : cta_pkg::ST_CHECK;
        end
      end
      cta_pkg::ST_EMPT: begin
        if (emp_done) state_d = cta_pkg::ST_CHECK;
      end
      cta_pkg::ST_CHECK: begin
        state_d = (too_long || need_w > fc_rd) ? cta_pkg::ST_DONE : cta_pkg::ST_SCAN1;
      end
      cta_pkg::ST_SCAN1: begin
        priority if (last_found) state_d = cta_pkg::ST_SCAN2;
        else if (scan_end)       state_d = cta_pkg::ST_DONE;
      end
      cta_pkg::ST_SCAN2: begin
        if (last_found) state_d = cta_pkg::ST_SEAL;
      end
      cta_pkg::ST_SEAL:   state_d = cta_pkg::ST_MIRROR;
      cta_pkg::ST_MIRROR: state_d = cta_pkg::ST_DONE;
      cta_pkg::ST_FMT: begin
        if (fmt_last) state_d = cta_pkg::ST_DONE;
      end
      cta_pkg::ST_WALK: begin
        if (walk_pend_q && walk_stop) state_d = cta_pkg::ST_MIRROR;
      end
      cta_pkg::ST_DONE: begin
        if (out_free) state_d = cta_pkg::ST_IDLE;
      end
      default: state_d = cta_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    op_d        = op_q;
    stat_d      = stat_q;
    t_d         = t_q;
    emp_d       = emp_q;
    best_d      = best_q;
    best_cnt_d  = best_cnt_q;
    ft_d        = ft_q;
    fe_d        = fe_q;
    q_d         = q_q;
    len_d       = len_q;
    rem_d       = rem_q;
    div_cnt_d   = div_cnt_q;
    need_d      = need_q;
    tail_d      = tail_q;
    found_d     = found_q;
    first_d     = first_q;
    prev_d      = prev_q;
    cnt_d       = cnt_q;
    cur_d       = cur_q;
    iss_d       = iss_q;
    rd_vld_d    = 1'b0;
    rd_e_d      = iss_q[7:0];
    walk_pend_d = walk_pend_q;
    fwd_d       = 1'b0;
    fc_d        = fc_q;
    out_valid_d = out_valid_q && !out_ready_i;
    o_stat_d    = o_stat_q;
    o_tid_d     = o_tid_q;
    o_head_d    = o_head_q;
    o_tail_d    = o_tail_q;
    o_free_d    = o_free_q;
    ram_we      = 1'b0;
    wr_table    = t_q;
    wr_entry    = prev_q;
    wr_data     = EndMark;
    rd_entry    = iss_q[7:0];

    unique case (state_q)
      cta_pkg::ST_IDLE: begin
        // Latch the transaction
        if (in_acc) begin
          op_d        = cta_pkg::opcode_e'(opcode_i);
          t_d         = sel_mod;
          len_d       = byte_length_i;
          rem_d       = '0;
          div_cnt_d   = 1'b0;
          cur_d       = chain_head_i;
          walk_pend_d = 1'b0;
          cnt_d       = fc_rd;
          ft_d        = '0;
          fe_d        = 8'd0;
          emp_d       = '0;
          best_d      = '0;
          best_cnt_d  = 8'd0;
          stat_d      = cta_pkg::STAT_OK;
          first_d     = FreeMark;
          tail_d      = '0;
        end
      end
      cta_pkg::ST_DIV: begin
        // Quotient first, then the remainder from it
        div_cnt_d = 1'b1;
        if (!div_cnt_q) begin
          q_d = 16'(div_prod >> DivShift);
        end else begin
          rem_d = RW'(div_rem);
        end
      end
      cta_pkg::ST_EMPT: begin
        // Track the largest free count, lowest table on a tie
        emp_d = emp_q + TW'(1);
        if (fc_rd > best_cnt_q) begin
          best_d     = emp_q;
          best_cnt_d = fc_rd;
        end
        if (emp_done) begin
          t_d = (fc_rd > best_cnt_q) ? emp_q : best_q;
        end
      end
      cta_pkg::ST_CHECK: begin
        need_d  = need_w;
        cnt_d   = fc_rd;
        iss_d   = 9'd0;
        found_d = 8'd0;
        priority if (too_long) begin
          stat_d = cta_pkg::STAT_TOO_LONG;
        end else if (need_w > fc_rd) begin
          stat_d = cta_pkg::STAT_NO_SPACE;
        end else begin
          tail_d = tail_adj;
        end
      end
      cta_pkg::ST_SCAN1: begin
        // Count free entries without touching the table
        iss_d    = iss_q[8] ? iss_q : iss_q + 9'd1;
        rd_vld_d = !iss_q[8];
        if (rd_hit) found_d = found_q + 8'd1;
        priority if (last_found) begin
          iss_d    = 9'd0;
          rd_vld_d = 1'b0;
          found_d  = 8'd0;
        end else if (scan_end) begin
          stat_d = cta_pkg::STAT_RAN_OUT;
          tail_d = '0;
        end
      end
      cta_pkg::ST_SCAN2: begin
        // Link each free entry found behind the previous one
        iss_d    = iss_q[8] ? iss_q : iss_q + 9'd1;
        rd_vld_d = !iss_q[8];
        if (rd_hit) begin
          found_d = found_q + 8'd1;
          prev_d  = rd_e_q;
          if (found_q == 8'd0) begin
            first_d = rd_e_q;
          end else begin
            ram_we  = 1'b1;
            wr_data = rd_e_q;
          end
        end
      end
      cta_pkg::ST_SEAL: begin
        // Close the chain and take it from the count
        ram_we = 1'b1;
        cnt_d  = cnt_q - need_q;
      end
      cta_pkg::ST_MIRROR: begin
        ram_we     = 1'b1;
        wr_entry   = FreeMark;
        wr_data    = cnt_q;
        fc_d[t_q]  = cnt_q;
      end
      cta_pkg::ST_FMT: begin
        // Sweep every entry of every table
        ram_we   = 1'b1;
        wr_table = ft_q;
        wr_entry = fe_q;
        priority if (fe_q == FreeMark) begin
          wr_data = (32'(ft_q) == ROOT_TABLE) ? cta_pkg::RootFreeCount
                                              : cta_pkg::FullFreeCount;
        end else if (fe_q == RootEntry && 32'(ft_q) == ROOT_TABLE) begin
          wr_data = EndMark;
        end else begin
          wr_data = FreeMark;
        end
        fe_d = fe_q + 8'd1;
        if (fe_q == 8'hFF) ft_d = ft_q + TW'(1);
        if (fmt_last) begin
          for (int k = 0; k < TABLE_COUNT; k++) begin
            fc_d[k] = (k == ROOT_TABLE) ? cta_pkg::RootFreeCount : cta_pkg::FullFreeCount;
          end
        end
      end
      cta_pkg::ST_WALK: begin
        // Free one link a cycle; forward a read of the entry just freed
        rd_entry = cur_q;
        if (!walk_pend_q) begin
          walk_pend_d = 1'b1;
        end else begin
          ram_we   = 1'b1;
          wr_entry = cur_q;
          wr_data  = FreeMark;
          cnt_d    = cnt_q + 8'd1;
          rd_entry = walk_data;
          cur_d    = walk_data;
          fwd_d    = (walk_data == cur_q);
          if (walk_stop) walk_pend_d = 1'b0;
        end
      end
      cta_pkg::ST_DONE: begin
        // Hand the result to the output register
        if (out_free) begin
          out_valid_d = 1'b1;
          o_stat_d    = stat_q;
          o_tid_d     = 2'(t_q);
          o_head_d    = first_q;
          o_tail_d    = 5'(tail_q);
          o_free_d    = fc_rd;
        end
      end
      default: begin
      end
    endcase
  end

  assign ram_waddr = AW'({wr_table, wr_entry});
  assign ram_raddr = AW'({t_q, rd_entry});

  cta_ram #(
    .WIDTH (8),
    .DEPTH (Depth)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_data),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cta_pkg::ST_IDLE;
      rd_vld_q    <= 1'b0;
      walk_pend_q <= 1'b0;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_vld_q    <= rd_vld_d;
      walk_pend_q <= walk_pend_d;
      fwd_q       <= fwd_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    stat_q     <= stat_d;
    t_q        <= t_d;
    emp_q      <= emp_d;
    best_q     <= best_d;
    best_cnt_q <= best_cnt_d;
    ft_q       <= ft_d;
    fe_q       <= fe_d;
    q_q        <= q_d;
    len_q      <= len_d;
    rem_q      <= rem_d;
    div_cnt_q  <= div_cnt_d;
    need_q     <= need_d;
    tail_q     <= tail_d;
    found_q    <= found_d;
    first_q    <= first_d;
    prev_q     <= prev_d;
    cnt_q      <= cnt_d;
    cur_q      <= cur_d;
    iss_q      <= iss_d;
    rd_e_q     <= rd_e_d;
    fc_q       <= fc_d;
    o_stat_q   <= o_stat_d;
    o_tid_q    <= o_tid_d;
    o_head_q   <= o_head_d;
    o_tail_q   <= o_tail_d;
    o_free_q   <= o_free_d;
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = o_stat_q;
  assign table_id_o   = o_tid_q;
  assign head_entry_o = o_head_q;
  assign tail_bytes_o = o_tail_q;
  assign free_left_o  = o_free_q;

  `CTA_ASSERT_IMP(a_idle_no_write, clk_i, rst_ni, state_q == cta_pkg::ST_IDLE, !ram_we)
  `CTA_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `CTA_ASSERT_IMP(a_link_below_need, clk_i, rst_ni, state_q == cta_pkg::ST_SCAN2, found_q < need_q)
  `CTA_ASSERT_IMP(a_result_from_done, clk_i, rst_ni, $rose(out_valid_o), $past(state_q == cta_pkg::ST_DONE))

endmodule
`default_nettype wire

@@ verif/tb_chained_table_allocator.sv @@
// Testbench for the chained table allocator: random and directed transactions against a predictor
`timescale 1ns / 1ps
`default_nettype none
module tb_chained_table_allocator;

  localparam int unsigned NumTables  = 4;
  localparam int unsigned SectorSize = 16;
  localparam logic [7:0]  FreeMark   = 8'd0;
  localparam logic [7:0]  EndMark    = 8'd255;
  localparam int unsigned RootTable  = 0;
  localparam int unsigned RootEntry  = 1;
  localparam int unsigned NumRandom  = 1150;

  typedef struct packed {
    cta_pkg::status_e status;
    logic [1:0]       table_id;
    logic [7:0]       head_entry;
    logic [4:0]       tail_bytes;
    logic [7:0]       free_left;
  } alloc_result_t;

  typedef struct packed {
    logic [1:0] tbl;
    logic [7:0] head;
  } chain_ref_t;

  // Shadow of the link tables; predicts one result per request
  class alloc_scoreboard;
    logic [7:0]    links [NumTables][256];
    logic [7:0]    counts[NumTables];
    alloc_result_t pending[$];
    chain_ref_t    live_chains[$];
    int unsigned   n_errors;
    int unsigned   n_checked;
    int unsigned   status_seen[4];

    function void walk_free(int unsigned t, logic [7:0] head);
      logic [7:0] e;
      logic [7:0] nxt;
      e = head;
      forever begin
        nxt = links[t][e];
        links[t][e] = FreeMark;
        counts[t] = counts[t] + 8'd1;
        if (nxt == EndMark || nxt == FreeMark) break;
        e = nxt;
      end
      links[t][FreeMark] = counts[t];
    endfunction

    function bit lowest_free(int unsigned t, output logic [7:0] idx);
      for (int e = 0; e < 256; e++) begin
        if (e == FreeMark || e == EndMark) continue;
        if (links[t][e] == FreeMark) begin
          idx = e[7:0];
          return 1'b1;
        end
      end
      idx = FreeMark;
      return 1'b0;
    endfunction

    function void note_request(cta_pkg::opcode_e op, logic [1:0] sel, logic [15:0] len,
                               logic [7:0] head);
      alloc_result_t r;
      int unsigned   t;
      int unsigned   sectors;
      int unsigned   tail;
      int unsigned   need;
      logic [7:0]    first;
      logic [7:0]    prev;
      logic [7:0]    e;
      bit            ok;
      t = sel % NumTables;
      r = '0;
      r.status = cta_pkg::STAT_OK;
      r.head_entry = FreeMark;
      case (op)
        cta_pkg::OP_FORMAT: begin
          for (int ti = 0; ti < NumTables; ti++) begin
            counts[ti] = (ti == RootTable) ? cta_pkg::RootFreeCount
                                           : cta_pkg::FullFreeCount;
            for (int ei = 0; ei < 256; ei++) links[ti][ei] = FreeMark;
            links[ti][FreeMark] = counts[ti];
            if (ti == RootTable) links[ti][RootEntry] = EndMark;
          end
          live_chains.delete();
        end
        cta_pkg::OP_FREE: walk_free(t, head);
        default: begin
          if (op == cta_pkg::OP_ALLOC_EMPTIEST) begin
            t = 0;
            for (int ti = 1; ti < NumTables; ti++)
              if (counts[t] < counts[ti]) t = ti;
          end
          sectors = len / SectorSize;
          tail = len % SectorSize;
          if (tail == 0 && sectors > 0) tail = SectorSize;
          need = sectors + 1 - ((tail == SectorSize) ? 1 : 0);
          if (sectors > cta_pkg::MaxSectors) begin
            r.status = cta_pkg::STAT_TOO_LONG;
          end else if (need > counts[t]) begin
            r.status = cta_pkg::STAT_NO_SPACE;
          end else begin
            first = FreeMark;
            prev = FreeMark;
            ok = 1'b1;
            for (int unsigned i = 1; i <= need; i++) begin
              if (!lowest_free(t, e)) begin
                // scan came up empty: close, account and hand back the partial chain
                if (i > 1) begin
                  links[t][prev] = EndMark;
                  counts[t] = counts[t] - 8'(i - 1);
                  walk_free(t, first);
                end
                ok = 1'b0;
                break;
              end
              links[t][e] = EndMark;
              if (i == 1) first = e;
              else links[t][prev] = e;
              prev = e;
            end
            if (ok) begin
              counts[t] = counts[t] - 8'(need);
              links[t][FreeMark] = counts[t];
              r.head_entry = first;
              r.tail_bytes = 5'(tail);
              live_chains.push_back('{tbl: 2'(t), head: first});
            end else begin
              r.status = cta_pkg::STAT_RAN_OUT;
            end
          end
        end
      endcase
      r.table_id = 2'(t);
      r.free_left = counts[t];
      pending.push_back(r);
    endfunction

    function void check_result(alloc_result_t got);
      alloc_result_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result status=%0d table=%0d", $time, got.status,
                 got.table_id);
        n_errors++;
        return;
      end
      exp_r = pending.pop_front();
      n_checked++;
      status_seen[exp_r.status]++;
      if (got.status !== exp_r.status)
        $display("%0t: status expected %0d actual %0d", $time, exp_r.status, got.status);
      if (got.table_id !== exp_r.table_id)
        $display("%0t: table_id expected %0d actual %0d", $time, exp_r.table_id,
                 got.table_id);
      if (got.head_entry !== exp_r.head_entry)
        $display("%0t: head_entry expected %0d actual %0d", $time, exp_r.head_entry,
                 got.head_entry);
      if (got.tail_bytes !== exp_r.tail_bytes)
        $display("%0t: tail_bytes expected %0d actual %0d", $time, exp_r.tail_bytes,
                 got.tail_bytes);
      if (got.free_left !== exp_r.free_left)
        $display("%0t: free_left expected %0d actual %0d", $time, exp_r.free_left,
                 got.free_left);
      if (got !== exp_r) n_errors++;
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  opcode_i = '0;
  logic [1:0]  table_select_i = '0;
  logic [15:0] byte_length_i = '0;
  logic [7:0]  chain_head_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic [1:0]  table_id_o;
  logic [7:0]  head_entry_o;
  logic [4:0]  tail_bytes_o;
  logic [7:0]  free_left_o;

  alloc_scoreboard sb = new();
  bit              calm;
  bit              stim_done;
  int unsigned     n_requests;
  int unsigned     op_seen[4];

  chained_table_allocator i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .opcode_i,
    .table_select_i,
    .byte_length_i,
    .chain_head_i,
    .out_valid_o,
    .out_ready_i,
    .status_o,
    .table_id_o,
    .head_entry_o,
    .tail_bytes_o,
    .free_left_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Present one transaction and hold it until accepted
  task automatic send_request(cta_pkg::opcode_e op, logic [1:0] sel, logic [15:0] len,
                              logic [7:0] head);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    opcode_i       <= op;
    table_select_i <= sel;
    byte_length_i  <= len;
    chain_head_i   <= head;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    sb.note_request(op, sel, len, head);
    n_requests++;
    op_seen[op]++;
  endtask

  // Pick a random transaction; mostly well-formed allocate and free traffic
  task automatic send_random();
    int unsigned pick;
    chain_ref_t  c;
    logic [15:0] len;
    pick = $urandom_range(0, 99);
    len = 16'($urandom_range(0, 300));
    if ($urandom_range(0, 9) == 0) len = 16'($urandom_range(0, 4200));
    if ($urandom_range(0, 29) == 0) len = 16'($urandom);
    if (pick < 2) begin
      send_request(cta_pkg::OP_FORMAT, 2'($urandom), 16'($urandom), 8'($urandom));
    end else if (pick < 32) begin
      send_request(cta_pkg::OP_ALLOC, 2'($urandom), len, 8'($urandom));
    end else if (pick < 55) begin
      send_request(cta_pkg::OP_ALLOC_EMPTIEST, 2'($urandom), len, 8'($urandom));
    end else if (pick < 90 && sb.live_chains.size() > 0) begin
      c = sb.live_chains[$urandom_range(0, sb.live_chains.size() - 1)];
      send_request(cta_pkg::OP_FREE, c.tbl, 16'($urandom), c.head);
    end else begin
      send_request(cta_pkg::OP_FREE, 2'($urandom), 16'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    calm = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: format first so no table is read before it is defined
    send_request(cta_pkg::OP_FORMAT, 2'd3, 16'hffff, 8'hff);
    send_request(cta_pkg::OP_ALLOC, 2'd0, 16'd0, 8'd0);
    send_request(cta_pkg::OP_ALLOC, 2'd1, 16'd1, 8'd0);
    send_request(cta_pkg::OP_ALLOC, 2'd2, 16'd15, 8'd0);
    send_request(cta_pkg::OP_ALLOC, 2'd3, 16'd16, 8'd0);
    send_request(cta_pkg::OP_ALLOC, 2'd3, 16'd17, 8'd0);
    send_request(cta_pkg::OP_ALLOC, 2'd0, 16'hffff, 8'd0);
    send_request(cta_pkg::OP_ALLOC, 2'd1, 16'd4080, 8'd0);
    send_request(cta_pkg::OP_ALLOC, 2'd1, 16'd4064, 8'd0);
    send_request(cta_pkg::OP_ALLOC_EMPTIEST, 2'd0, 16'd4064, 8'd0);
    send_request(cta_pkg::OP_ALLOC_EMPTIEST, 2'd0, 16'd4000, 8'd0);
    send_request(cta_pkg::OP_ALLOC_EMPTIEST, 2'd0, 16'd33, 8'd0);
    send_request(cta_pkg::OP_FREE, 2'd1, 16'd0, 8'd2);
    send_request(cta_pkg::OP_FREE, 2'd0, 16'd0, 8'd0);
    send_request(cta_pkg::OP_FREE, 2'd0, 16'd0, 8'd255);
    send_request(cta_pkg::OP_FREE, 2'd2, 16'd0, 8'd200);
    // Free entries already free to inflate the count, then allocate to run out mid-scan
    send_request(cta_pkg::OP_FREE, 2'd2, 16'd0, 8'd201);
    send_request(cta_pkg::OP_ALLOC, 2'd2, 16'd4064, 8'd0);
    send_request(cta_pkg::OP_ALLOC, 2'd2, 16'd4064, 8'd0);
    send_request(cta_pkg::OP_FORMAT, 2'd0, 16'd0, 8'd0);
    for (int i = 0; i < NumRandom; i++) begin
      if (i % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      send_random();
    end
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver may stall before each result; never in calm stretches
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  // Check each result transaction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result('{status: cta_pkg::status_e'(status_o), table_id: table_id_o,
                        head_entry: head_entry_o, tail_bytes: tail_bytes_o,
                        free_left: free_left_o});
  end

  // Drain and report
  initial begin
    wait (stim_done);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (1200) @(posedge clk_i);
    $display("%0d requests (alloc %0d, emptiest %0d, free %0d, format %0d), %0d results",
             n_requests, op_seen[cta_pkg::OP_ALLOC], op_seen[cta_pkg::OP_ALLOC_EMPTIEST],
             op_seen[cta_pkg::OP_FREE], op_seen[cta_pkg::OP_FORMAT], sb.n_checked);
    $display("statuses: ok %0d, too long %0d, no space %0d, ran out %0d",
             sb.status_seen[cta_pkg::STAT_OK], sb.status_seen[cta_pkg::STAT_TOO_LONG],
             sb.status_seen[cta_pkg::STAT_NO_SPACE], sb.status_seen[cta_pkg::STAT_RAN_OUT]);
    if (sb.n_errors == 0 && sb.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #64000000;
    $display("simulation failed");
    $finish;
  end

endmodule
`default_nettype wire
